/* hdl/sscf_pkg.sv */
package sscf_pkg;

    // Frame kinds carried on the op field.
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_DISPLAY = 2'd1,
        OP_NUMBER  = 2'd2
    } op_t;

    // Command bytes.
    localparam logic [7:0] CMD_DATA_MODE  = 8'b0100_0000;
    localparam logic [7:0] CMD_DISPLAY    = 8'b1000_0000;
    localparam logic [7:0] CMD_ADDRESS    = 8'b1100_0000;
    localparam logic [7:0] DISPLAY_ON_BIT = 8'h08;
    localparam logic [7:0] POINT_BIT      = 8'h80;

    // Reciprocal constants for the digit split. Each one gives the exact quotient
    // over the range of values that reaches it.
    localparam logic [13:0] THOU_RECIP = 14'd8389;   // floor(n * 8389 / 2^23) = n / 1000
    localparam logic [13:0] THOUSAND   = 14'd1000;
    localparam logic [15:0] HUND_RECIP = 16'd41;     // floor(r * 41 / 2^12) = r / 100
    localparam logic [9:0]  HUNDRED    = 10'd100;
    localparam logic [14:0] TEN_RECIP  = 15'd205;    // floor(r * 205 / 2^11) = r / 10
    localparam logic [6:0]  TEN        = 7'd10;

    // Queue between the front and the back.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Byte positions within a number frame.
    typedef enum logic [2:0] {
        STEP_HEAD = 3'd0,
        STEP_THOU = 3'd1,
        STEP_HUND = 3'd2,
        STEP_TENS = 3'd3,
        STEP_ONES = 3'd4
    } step_t;

    // One classified command, as handed from the front to the back.
    typedef struct packed {
        logic       multi;      // number frame with four digit bytes after the head
        logic [7:0] head_byte;
        logic       point;
        logic [4:0] thou;       // may reach 16, which shows blank
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } cmd_t;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'b0011_1111, 8'b0000_0110, 8'b0101_1011, 8'b0100_1111,
        8'b0110_0110, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C,
        8'h39, 8'h5E, 8'h79, 8'h71
    };

    // Segment pattern of a digit; anything above F is blank.
    function automatic logic [7:0] digit_segments(input logic [4:0] digit);
        logic [7:0] seg;
        if (digit[4])
        begin
            seg = 8'h00;
        end
        else
        begin
            seg = SEG_TABLE[digit[3:0]];
        end
        return seg;
    endfunction

endpackage

/* hdl/sscf_front.sv */
module sscf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         op,
    input  logic [13:0]        number,
    input  logic               point_on,
    input  logic               display_on,
    input  logic [2:0]         brightness,
    output logic               cmd_push,
    output sscf_pkg::cmd_t     cmd,
    input  logic               queue_full
);
    import sscf_pkg::*;

    typedef struct packed {
        logic        multi;
        logic [7:0]  head_byte;
        logic        point;
        logic [13:0] number;
        logic [4:0]  thou;
        logic [9:0]  rest;
        logic [3:0]  hund;
        logic [6:0]  rem2;
        logic [3:0]  tens;
        logic [3:0]  ones;
    } stage_t;

    localparam int STAGES = 7;

    logic [STAGES-1:0] valid_reg;
    stage_t            s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    stage_t            s0_next, s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
    logic              advance;
    logic              in_ok;
    logic [27:0]       prod1;
    logic [13:0]       diff2;
    logic [15:0]       prod3;
    logic [9:0]        diff4;
    logic [14:0]       prod5;
    logic [6:0]        diff6;

    // All stages move together unless the last one holds a word the queue cannot take.
    assign advance  = !valid_reg[STAGES-1] || !queue_full;
    assign full     = !advance;
    assign cmd_push = valid_reg[STAGES-1] && !queue_full;

    always_comb
    begin
        s0_next        = '0;
        s0_next.number = number;
        s0_next.point  = point_on;
        in_ok          = push && advance;
        case (op)
            OP_INIT:
            begin
                s0_next.head_byte = CMD_DATA_MODE;
            end
            OP_DISPLAY:
            begin
                s0_next.head_byte = CMD_DISPLAY | (display_on ? DISPLAY_ON_BIT : 8'h00)
                                    | {5'b0, brightness};
            end
            OP_NUMBER:
            begin
                s0_next.head_byte = CMD_ADDRESS;
                s0_next.multi     = 1'b1;
            end
            default:
            begin
                // The unused code produces no frame at all.
                in_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        prod1 = 28'(s0_reg.number) * 28'(THOU_RECIP);
        s1_next = s0_reg;
        s1_next.thou = prod1[27:23];

        diff2 = s1_reg.number - 14'(14'(s1_reg.thou) * THOUSAND);
        s2_next = s1_reg;
        s2_next.rest = diff2[9:0];

        prod3 = 16'(s2_reg.rest) * HUND_RECIP;
        s3_next = s2_reg;
        s3_next.hund = prod3[15:12];

        diff4 = s3_reg.rest - 10'(10'(s3_reg.hund) * HUNDRED);
        s4_next = s3_reg;
        s4_next.rem2 = diff4[6:0];

        prod5 = 15'(s4_reg.rem2) * TEN_RECIP;
        s5_next = s4_reg;
        s5_next.tens = prod5[14:11];

        diff6 = s5_reg.rem2 - 7'(7'(s5_reg.tens) * TEN);
        s6_next = s5_reg;
        s6_next.ones = diff6[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    always_comb
    begin
        cmd.multi     = s6_reg.multi;
        cmd.head_byte = s6_reg.head_byte;
        cmd.point     = s6_reg.point;
        cmd.thou      = s6_reg.thou;
        cmd.hund      = s6_reg.hund;
        cmd.tens      = s6_reg.tens;
        cmd.ones      = s6_reg.ones;
    end

endmodule

/* hdl/sscf_queue.sv */
module sscf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sscf_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           not_empty,
    output sscf_pkg::cmd_t rd_data
);
    import sscf_pkg::*;

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_wr, do_rd;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/sscf_back.sv */
module sscf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  sscf_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     frame_byte,
    output logic           frame_first,
    output logic           last
);
    import sscf_pkg::*;

    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       last_reg;
    logic       load;
    logic [7:0] byte_sel;
    logic [7:0] point_mask;
    logic       is_last;

    assign empty       = !out_valid_reg;
    assign frame_byte  = byte_reg;
    assign frame_first = first_reg;
    assign last        = last_reg;

    // A new byte enters the output register whenever a command waits and the register is free or being taken.
    assign load    = cmd_valid && (!out_valid_reg || pop);
    assign is_last = !cmd.multi || (step_reg == STEP_ONES);
    assign cmd_pop = load && is_last;

    always_comb
    begin
        point_mask = cmd.point ? POINT_BIT : 8'h00;
        case (step_reg)
            STEP_HEAD: byte_sel = cmd.head_byte;
            STEP_THOU: byte_sel = digit_segments(cmd.thou) | point_mask;
            STEP_HUND: byte_sel = digit_segments({1'b0, cmd.hund}) | point_mask;
            STEP_TENS: byte_sel = digit_segments({1'b0, cmd.tens}) | point_mask;
            default:   byte_sel = digit_segments({1'b0, cmd.ones}) | point_mask;
        endcase

        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = is_last ? STEP_HEAD : step_t'(step_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_sel;
            first_reg <= (step_reg == STEP_HEAD);
            last_reg  <= is_last;
        end
    end

endmodule

/* hdl/seven_segment_command_frame_encoder_unit.sv */
// Channel   Handshake            Ports
// -------   ------------------   -----------------------------------------------
// command   push / full          op, number, point_on, display_on, brightness
// bytes     empty / pop          frame_byte, frame_first, last
//
// A command word can enter on every cycle that full is low; it passes through the
// digit-split pipeline and then waits in a four-entry queue.
// The byte sequencer sends one byte per cycle while pop is high: one for an init or
// display command and five for a write-number command, so a stream of write-number
// commands is paced by their five bytes through the single output register.
// Reset clears the pipeline valid bits, the queue pointers, the byte counter and the
// output flag; no byte is waiting afterward.
// When pop stays low the output byte holds, the queue fills, the pipeline stops, and
// full rises; an op code of three is taken and dropped without any byte.
module seven_segment_command_frame_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [13:0] number,
    input  logic        point_on,
    input  logic        display_on,
    input  logic [2:0]  brightness,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        frame_first,
    output logic        last
);
    import sscf_pkg::*;

    // Classified command leaving the front pipeline.
    cmd_t front_cmd;
    logic front_push;
    logic queue_full;

    // Head of the queue as seen by the sequencer.
    cmd_t head_cmd;
    logic head_valid;
    logic head_pop;

    // The front splits the number into decimal digits by reciprocal multiplies and
    // back-subtraction, and turns the other commands into their single byte.
    sscf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .number     (number),
        .point_on   (point_on),
        .display_on (display_on),
        .brightness (brightness),
        .cmd_push   (front_push),
        .cmd        (front_cmd),
        .queue_full (queue_full)
    );

    // The queue lets the front keep accepting while the sequencer works through a frame.
    sscf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_push),
        .wr_data   (front_cmd),
        .full      (queue_full),
        .rd_en     (head_pop),
        .not_empty (head_valid),
        .rd_data   (head_cmd)
    );

    // The sequencer walks each command byte by byte, looks up the segment patterns, and
    // marks the first and final byte of every frame.
    sscf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (head_valid),
        .cmd         (head_cmd),
        .cmd_pop     (head_pop),
        .empty       (empty),
        .pop         (pop),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .last        (last)
    );

endmodule

/* sim/seven_segment_command_frame_encoder_unit_tb.sv */
module seven_segment_command_frame_encoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sscf_pkg::OP_INIT;
    import sscf_pkg::OP_DISPLAY;
    import sscf_pkg::OP_NUMBER;

    // The fourth op code has no frame; the block must swallow it silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Command bytes of the display protocol, kept apart from the design's copies.
    localparam logic [7:0] DATA_MODE_CMD = 8'h40;
    localparam logic [7:0] DISPLAY_CMD   = 8'h80;
    localparam logic [7:0] ADDRESS_CMD   = 8'hC0;
    localparam logic [7:0] SCREEN_ON     = 8'h08;
    localparam logic [7:0] DOT_SEGMENT   = 8'h80;

    // One byte of a frame, together with its start and stop flags.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       fin;
    } frame_word_t;

    // The scoreboard turns each accepted command into the bytes of its frame and
    // matches the bytes that come out of the block against them, in order.
    class frame_scoreboard;
        frame_word_t expected_bytes[$];
        int          failures = 0;

        // Hex font in XGFEDCBA order; a thousands digit of 16 shows nothing.
        function automatic logic [7:0] segments_of(int digit);
            logic [7:0] pattern;
            case (digit)
                0:       pattern = 8'h3F;
                1:       pattern = 8'h06;
                2:       pattern = 8'h5B;
                3:       pattern = 8'h4F;
                4:       pattern = 8'h66;
                5:       pattern = 8'h6D;
                6:       pattern = 8'h7D;
                7:       pattern = 8'h07;
                8:       pattern = 8'h7F;
                9:       pattern = 8'h6F;
                10:      pattern = 8'h77;
                11:      pattern = 8'h7C;
                12:      pattern = 8'h39;
                13:      pattern = 8'h5E;
                14:      pattern = 8'h79;
                15:      pattern = 8'h71;
                default: pattern = 8'h00;
            endcase
            return pattern;
        endfunction

        function void note_command(logic [1:0] kind, logic [13:0] value, logic point,
                                   logic on, logic [2:0] level);
            logic [7:0] dot;
            int         rest;
            dot  = point ? DOT_SEGMENT : 8'h00;
            rest = int'(value) % 1000;
            case (kind)
                OP_INIT:
                begin
                    expected_bytes.push_back({DATA_MODE_CMD, 1'b1, 1'b1});
                end
                OP_DISPLAY:
                begin
                    expected_bytes.push_back({DISPLAY_CMD | (on ? SCREEN_ON : 8'h00)
                                              | {5'b0, level}, 1'b1, 1'b1});
                end
                OP_NUMBER:
                begin
                    expected_bytes.push_back({ADDRESS_CMD, 1'b1, 1'b0});
                    expected_bytes.push_back({segments_of(int'(value) / 1000) | dot,
                                              1'b0, 1'b0});
                    expected_bytes.push_back({segments_of(rest / 100) | dot, 1'b0, 1'b0});
                    expected_bytes.push_back({segments_of((rest / 10) % 10) | dot,
                                              1'b0, 1'b0});
                    expected_bytes.push_back({segments_of(rest % 10) | dot, 1'b0, 1'b1});
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_word(logic [7:0] data, logic first, logic fin);
            frame_word_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual data %02h first %b last %b",
                         $time, data, first, fin);
                failures++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                         $time, want.data, data);
                failures++;
            end
            if (first !== want.first)
            begin
                $display("%0t: frame_first mismatch, expected %b, actual %b",
                         $time, want.first, first);
                failures++;
            end
            if (fin !== want.fin)
            begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.fin, fin);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  op = 2'd0;
    logic [13:0] number = 14'd0;
    logic        point_on = 1'b0;
    logic        display_on = 1'b0;
    logic [2:0]  brightness = 3'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        last;

    // Chance in percent that the sender or the receiver sits out a given cycle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    frame_scoreboard sb = new();

    seven_segment_command_frame_encoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .number      (number),
        .point_on    (point_on),
        .display_on  (display_on),
        .brightness  (brightness),
        .empty       (empty),
        .pop         (pop),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .last        (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver side. The pop decision is made fresh every cycle, so stalls land on
    // any byte of a frame, including the head and the closing digit.
    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Everything here reads the values from just before the edge, so a word popped
    // at this edge is the one that was sitting on the result ports.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_word(frame_byte, frame_first, last);
        end
    end

    // Offers one command word, possibly after a few idle cycles, and holds it until
    // the block takes it. Push stays high on return so that back-to-back words do
    // not open a bubble unless the next call decides to idle.
    task automatic send_word(logic [1:0] kind, logic [13:0] value, logic point,
                             logic on, logic [2:0] level);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        op         <= kind;
        number     <= value;
        point_on   <= point;
        display_on <= on;
        brightness <= level;
        do
        begin
            @(posedge clk);
        end
        while (full);
        sb.note_command(kind, value, point, on, level);
    endtask

    // Random commands. Most are write-number frames since they exercise the digit
    // split; their values lean toward the plain decimal range but also cover the
    // hex thousands digits, the blank thousands digit, and the full 14-bit range.
    // Fields that the chosen op ignores always carry random junk. Dropped op codes
    // are mixed in but are not counted.
    task automatic send_random(int count);
        int          sent;
        int          pick;
        logic [1:0]  kind;
        logic [13:0] value;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                kind = OP_INIT;
            end
            else if (pick < 22)
            begin
                kind = OP_DISPLAY;
            end
            else if (pick < 95)
            begin
                kind = OP_NUMBER;
            end
            else
            begin
                kind = OP_UNUSED;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: value = 14'($urandom_range(9999));
                6, 7:             value = 14'($urandom_range(15999, 10000));
                8:                value = 14'($urandom_range(16383, 16000));
                default:          value = 14'($urandom_range(16383));
            endcase
            send_word(kind, value, 1'($urandom), 1'($urandom), 3'($urandom));
            if (kind != OP_UNUSED)
            begin
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender is mostly busy and the receiver stalls often,
        // which lets the queue fill and full push back on the sender.
        send_idle_pct = 23;
        recv_idle_pct = 57;

        // Directed words: both single-byte commands with their fields at the
        // extremes, numbers at the ends of the decimal and hex ranges, the blank
        // thousands digit, and the dropped op code between real commands.
        send_word(OP_INIT, 14'h3FFF, 1'b1, 1'b1, 3'd7);
        send_word(OP_INIT, 14'd0, 1'b0, 1'b0, 3'd0);
        send_word(OP_DISPLAY, 14'd0, 1'b0, 1'b0, 3'd0);
        send_word(OP_DISPLAY, 14'h3FFF, 1'b1, 1'b1, 3'd7);
        send_word(OP_DISPLAY, 14'd5, 1'b0, 1'b1, 3'd0);
        send_word(OP_DISPLAY, 14'd9, 1'b1, 1'b0, 3'd7);
        send_word(OP_NUMBER, 14'd0, 1'b0, 1'b1, 3'd7);
        send_word(OP_NUMBER, 14'd0, 1'b1, 1'b0, 3'd0);
        send_word(OP_NUMBER, 14'd9999, 1'b0, 1'b0, 3'd0);
        send_word(OP_NUMBER, 14'd9999, 1'b1, 1'b1, 3'd7);
        send_word(OP_NUMBER, 14'd1234, 1'b0, 1'b0, 3'd3);
        send_word(OP_NUMBER, 14'd5678, 1'b1, 1'b0, 3'd4);
        send_word(OP_UNUSED, 14'd4321, 1'b1, 1'b1, 3'd7);
        send_word(OP_NUMBER, 14'd10000, 1'b0, 1'b0, 3'd0);
        send_word(OP_NUMBER, 14'd12345, 1'b1, 1'b1, 3'd2);
        send_word(OP_NUMBER, 14'd15999, 1'b0, 1'b1, 3'd5);
        send_word(OP_UNUSED, 14'h3FFF, 1'b0, 1'b0, 3'd0);
        send_word(OP_UNUSED, 14'd0, 1'b1, 1'b0, 3'd1);
        send_word(OP_NUMBER, 14'd16000, 1'b0, 1'b0, 3'd6);
        send_word(OP_NUMBER, 14'd16383, 1'b1, 1'b1, 3'd7);
        send_word(OP_NUMBER, 14'd16383, 1'b0, 1'b0, 3'd0);
        send_word(OP_INIT, 14'd7, 1'b0, 1'b1, 3'd2);

        send_random(48);

        // Second phase: the sender trickles and the receiver rarely stalls, so the
        // block often drains completely between words.
        send_idle_pct = 57;
        recv_idle_pct = 23;
        send_random(48);

        // Last phase: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(47);
        push <= 1'b0;

        // Let every frame drain, then give the pipeline time to show any stray byte.
        while (sb.expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog. A correct run needs well under a tenth of this even with every
    // frame at five bytes and the receiver stalling more than half the time.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
